[rtl/core/kcv_pkg.sv]
package kcv_pkg;

   // fixed-point format of every value
   localparam int FRAC   = 16;
   localparam int ONE_I  = 1 << FRAC;
   // wide signed working width for sums of rounded products
   localparam int WW     = 54;
   // divider: numerator holds a 32-bit value shifted by FRAC plus a rounding term
   localparam int DIV_NW = 32 + FRAC + 1;
   localparam int DIV_DW = 33;

   localparam logic [16:0] ONE17 = 17'(ONE_I);

   // reset values of the configuration registers
   localparam logic [31:0] RST_T     = 32'd52429;
   localparam logic [31:0] RST_Q     = 32'd655;
   localparam logic [31:0] RST_POS   = 32'd6554;
   localparam logic [31:0] RST_CROSS = 32'd19661;
   localparam logic [31:0] RST_VEL   = 32'd26214;

   // measurement noise steps
   localparam logic [31:0] REL_A   = 32'(5 << (FRAC - 1));
   localparam logic [31:0] REL_B   = 32'(8 << FRAC);
   localparam logic [31:0] REL_C   = 32'(20 << FRAC);
   localparam logic [31:0] NOISE_A = 32'((ONE_I + 10) / 20);
   localparam logic [31:0] NOISE_B = 32'((ONE_I + 2) / 5);
   localparam logic [31:0] NOISE_C = 32'(ONE_I / 2);
   // divide by 40 as a divide by 8 and a reciprocal multiply by 1/5 (shift 34)
   localparam logic [31:0] NOISE_RCP = 32'hCCCC_CCCD;
   localparam logic [31:0] NOISE_RND = 32'd20;

   typedef struct packed {
      logic               go;
      logic               first;
      logic [16:0]        kx;
      logic signed [31:0] kv;
      logic [31:0]        t;
   } lane_ctrl_type;

   function automatic logic signed [WW-1:0] ext_s(input logic [31:0] v);
      return $signed({{(WW-32){v[31]}}, v});
   endfunction

   function automatic logic signed [WW-1:0] ext_u(input logic [31:0] v);
      return $signed({{(WW-32){1'b0}}, v});
   endfunction

   // round half away from zero on the magnitude, then reapply the sign
   function automatic logic signed [WW-1:0] qround(input logic [63:0] p, input logic neg);
      logic [64:0]   s;
      logic [WW-1:0] r;
      s = {1'b0, p} + (65'(1) << (FRAC - 1));
      r = WW'(s >> FRAC);
      return neg ? -$signed(r) : $signed(r);
   endfunction

   function automatic logic [31:0] sat_s(input logic signed [WW-1:0] v);
      if (!v[WW-1] && (|v[WW-2:31])) begin
         return 32'h7FFF_FFFF;
      end else if (v[WW-1] && !(&v[WW-2:31])) begin
         return 32'h8000_0000;
      end
      return v[31:0];
   endfunction

   function automatic logic [31:0] sat_u(input logic signed [WW-1:0] v);
      if (v[WW-1]) begin
         return 32'd0;
      end else if (|v[WW-2:32]) begin
         return 32'hFFFF_FFFF;
      end
      return v[31:0];
   endfunction

   function automatic logic [31:0] mag32(input logic signed [WW-1:0] v);
      logic [WW-1:0] m;
      m = v[WW-1] ? WW'(-v) : WW'(v);
      if (|m[WW-1:32]) begin
         return 32'hFFFF_FFFF;
      end
      return m[31:0];
   endfunction

endpackage

[rtl/core/kalman_cv_position_tracker.sv]
// channel | dir | transfer when          | payload
// req     | in  | req_tvalid & tready    | tuser: start_track; tdata: meas_x/y/z, reliability
// rsp     | out | rsp_tvalid & tready    | tdata: est_x/y/z, pos_gain, meas_noise, pos_variance
// csr     | in  | psel&penable&pwrite    | five 32-bit registers at 4*index
//
// A first fix of a track skips the divisions and the lane update; a tracking fix runs them:
// four divisions share one divider that retires one quotient bit a cycle;
// the divide by 40 for the noise step is a reciprocal multiply.
// One item is in flight; the next is taken while the finished result sits in the output
// register. Reset is synchronous and restores registers and track state; no clearing pass.
module kalman_cv_position_tracker import kcv_pkg::*; #(
   parameter int AXES = 3
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,   // meas_x, meas_y, meas_z, reliability
   input  logic [0:0]   req_tuser,   // start_track
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [183:0] rsp_tdata,   // est_x, est_y, est_z, pos_gain(17), meas_noise,
                                     // pos_variance, zero pad
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [4:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   localparam logic [2:0] REG_T     = 3'd0;
   localparam logic [2:0] REG_Q     = 3'd1;
   localparam logic [2:0] REG_POS   = 3'd2;
   localparam logic [2:0] REG_CROSS = 3'd3;
   localparam logic [2:0] REG_VEL   = 3'd4;

   logic [31:0]   t_ff, q_ff, pos_ff, cross_ff, vel_ff;
   logic [2:0]    reg_idx;
   logic          csr_wr;
   logic [127:0]  in_ff;
   logic          first_ff;
   logic          go_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [183:0]  rsp_data_ff;
   logic          idle, res_valid, out_free, load;
   logic [2:0]    busy;
   logic [31:0]   est [3];
   logic [16:0]   res_kx;
   logic [31:0]   res_noise, res_var;
   lane_ctrl_type lane_ctrl;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[4:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         t_ff     <= RST_T;
         q_ff     <= RST_Q;
         pos_ff   <= RST_POS;
         cross_ff <= RST_CROSS;
         vel_ff   <= RST_VEL;
      end else if (csr_wr) begin
         unique case (reg_idx)
            REG_T:     t_ff     <= csr_pwdata;
            REG_Q:     q_ff     <= csr_pwdata;
            REG_POS:   pos_ff   <= csr_pwdata;
            REG_CROSS: cross_ff <= csr_pwdata;
            REG_VEL:   vel_ff   <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_T:     csr_prdata = t_ff;
         REG_Q:     csr_prdata = q_ff;
         REG_POS:   csr_prdata = pos_ff;
         REG_CROSS: csr_prdata = cross_ff;
         REG_VEL:   csr_prdata = vel_ff;
         default:   csr_prdata = '0;
      endcase
   end

   // hold the accepted item for the whole computation
   assign req_tready = idle && !go_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         go_ff <= 1'b0;
      end else begin
         go_ff <= req_tvalid && req_tready;
      end
      if (req_tvalid && req_tready) begin
         in_ff    <= req_tdata;
         first_ff <= req_tuser[0];
      end
   end

   kcv_gain u_gain (
      .clock      (clock),
      .reset      (reset),
      .item_go    (go_ff),
      .item_first (first_ff),
      .item_rel   (in_ff[127:96]),
      .cfg_t      (t_ff),
      .cfg_q      (q_ff),
      .cfg_pos    (pos_ff),
      .cfg_cross  (cross_ff),
      .cfg_vel    (vel_ff),
      .lanes_busy (|busy),
      .out_free   (out_free),
      .idle       (idle),
      .res_valid  (res_valid),
      .lane_ctrl  (lane_ctrl),
      .res_kx     (res_kx),
      .res_noise  (res_noise),
      .res_var    (res_var)
   );

   for (genvar g = 0; g < 3; g++) begin : g_lane
      if (g < AXES) begin : g_on
         kcv_lane u_lane (
            .clock (clock),
            .reset (reset),
            .ctrl  (lane_ctrl),
            .meas  (in_ff[32*g +: 32]),
            .busy  (busy[g]),
            .pos   (est[g])
         );
      end else begin : g_off
         assign busy[g] = 1'b0;
         assign est[g]  = '0;
      end
   end

   // merge lane positions with the shared gain and variance
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign load     = res_valid && out_free;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (load) begin
         rsp_data_ff <= {7'd0, res_var, res_noise, res_kx, est[2], est[1], est[0]};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

[rtl/core/kcv_div.sv]
module kcv_div import kcv_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DIV_NW-1:0] num,
   input  logic [DIV_DW-1:0] den,
   output logic              done,
   output logic [DIV_NW-1:0] quot
);

   localparam int CW = $clog2(DIV_NW + 1);

   logic [DIV_DW-1:0] rem_ff, rem_in;
   logic [DIV_NW-1:0] quo_ff, quo_in;
   logic [DIV_DW-1:0] den_ff;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DIV_DW:0]   trial;
   logic              fits;

   // one quotient bit a cycle, restoring
   assign trial = {rem_ff, quo_ff[DIV_NW-1]};
   assign fits  = trial >= {1'b0, den_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = num;
         cnt_in  = CW'(DIV_NW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? DIV_DW'(trial - {1'b0, den_ff}) : trial[DIV_DW-1:0];
         quo_in = {quo_ff[DIV_NW-2:0], fits};
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (start) begin
         den_ff <= den;
      end
   end

   assign done = done_ff;
   assign quot = quo_ff;

endmodule

[rtl/core/kcv_lane.sv]
module kcv_lane import kcv_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  lane_ctrl_type      ctrl,
   input  logic [31:0]        meas,
   output logic               busy,
   output logic [31:0]        pos
);

   localparam logic [2:0] L_IDLE = 3'd0;
   localparam logic [2:0] L_A    = 3'd1;
   localparam logic [2:0] L_B    = 3'd2;
   localparam logic [2:0] L_C    = 3'd3;
   localparam logic [2:0] L_D    = 3'd4;

   logic [2:0]           state_ff, state_in;
   logic [31:0]          pos_ff, vel_ff, xhat_ff;
   logic signed [WW-1:0] y_ff, y;
   logic [63:0]          prod_ff;
   logic                 neg_ff;
   logic [31:0]          ma, mb;
   logic                 mneg;
   logic signed [WW-1:0] qres;

   assign y    = ext_s(meas) - ext_s(xhat_ff);
   assign qres = qround(prod_ff, neg_ff);

   always_comb begin
      ma   = mag32(ext_s(vel_ff));
      mb   = ctrl.t;
      mneg = vel_ff[31];
      unique case (state_ff)
         L_B: begin
            ma   = mag32(y);
            mb   = {15'd0, ctrl.kx};
            mneg = y[WW-1];
         end
         L_C: begin
            ma   = mag32(y_ff);
            mb   = mag32(ext_s(ctrl.kv));
            mneg = y_ff[WW-1] ^ ctrl.kv[31];
         end
         default: ;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         L_IDLE: if (ctrl.go && !ctrl.first) begin
            state_in = L_A;
         end
         L_A: state_in = L_B;
         L_B: state_in = L_C;
         L_C: state_in = L_D;
         L_D: state_in = L_IDLE;
         default: state_in = L_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= L_IDLE;
         pos_ff   <= '0;
         vel_ff   <= '0;
      end else begin
         state_ff <= state_in;
         unique case (state_ff)
            L_IDLE: if (ctrl.go && ctrl.first) begin
               pos_ff <= meas;
               vel_ff <= '0;
            end
            L_C: pos_ff <= sat_s(ext_s(xhat_ff) + qres);
            L_D: vel_ff <= sat_s(ext_s(vel_ff) + qres);
            default: ;
         endcase
      end
      prod_ff <= 64'(ma) * 64'(mb);
      neg_ff  <= mneg;
      if (state_ff == L_A) begin
         xhat_ff <= sat_s(ext_s(pos_ff) + qres);
      end
      if (state_ff == L_B) begin
         y_ff <= y;
      end
   end

   assign busy = state_ff != L_IDLE;
   assign pos  = pos_ff;

endmodule

[rtl/core/kcv_gain.sv]
module kcv_gain import kcv_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          item_go,
   input  logic          item_first,
   input  logic [31:0]   item_rel,
   input  logic [31:0]   cfg_t,
   input  logic [31:0]   cfg_q,
   input  logic [31:0]   cfg_pos,
   input  logic [31:0]   cfg_cross,
   input  logic [31:0]   cfg_vel,
   input  logic          lanes_busy,
   input  logic          out_free,
   output logic          idle,
   output logic          res_valid,
   output lane_ctrl_type lane_ctrl,
   output logic [16:0]   res_kx,
   output logic [31:0]   res_noise,
   output logic [31:0]   res_var
);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_RDIV = 4'd1;
   localparam logic [3:0] S_QT   = 4'd2;
   localparam logic [3:0] S_QTT  = 4'd3;
   localparam logic [3:0] S_P1   = 4'd4;
   localparam logic [3:0] S_P2   = 4'd5;
   localparam logic [3:0] S_P3   = 4'd6;
   localparam logic [3:0] S_P4   = 4'd7;
   localparam logic [3:0] S_KX   = 4'd8;
   localparam logic [3:0] S_KXW  = 4'd9;
   localparam logic [3:0] S_KVW  = 4'd10;
   localparam logic [3:0] S_U1   = 4'd11;
   localparam logic [3:0] S_U2   = 4'd12;
   localparam logic [3:0] S_U3   = 4'd13;
   localparam logic [3:0] S_WAIT = 4'd14;
   localparam logic [3:0] S_DONE = 4'd15;

   logic [3:0]           state_ff, state_in;
   logic [31:0]          r_ff, qt_ff, tt_ff;
   logic [DIV_NW-1:0]    qtt_ff;
   logic signed [WW-1:0] m1_ff, m2_ff;
   logic [31:0]          ppxx_ff, ppxv_ff, ppvv_ff;
   logic [16:0]          kx_ff;
   logic [31:0]          kv_ff;
   logic [31:0]          vpos_ff, vcross_ff, vvel_ff;
   logic [63:0]          prod_ff;
   logic                 neg_ff;

   logic [31:0]          t_eff, ma, mb, qt_sat, noise, ppxv_mag;
   logic                 mneg;
   logic signed [WW-1:0] qres, kv_wide;
   logic [16:0]          one_m_kx;
   logic [DIV_DW-1:0]    s_sum;
   logic                 div_start, div_done;
   logic [DIV_NW-1:0]    div_num, div_quot;
   logic [DIV_DW-1:0]    div_den;
   logic [32:0]          rel_sum;
   logic [63:0]          rel_prod;

   assign t_eff    = (cfg_t == '0) ? 32'd1 : cfg_t;
   assign qres     = qround(prod_ff, neg_ff);
   assign one_m_kx = ONE17 - kx_ff;
   assign ppxv_mag = mag32(ext_s(ppxv_ff));
   assign s_sum    = {1'b0, ppxx_ff} + {1'b0, r_ff};
   assign qt_sat   = (|div_quot[DIV_NW-1:32]) ? 32'hFFFF_FFFF : div_quot[31:0];
   assign kv_wide  = ppxv_ff[31] ? -$signed(WW'(div_quot)) : $signed(WW'(div_quot));

   // (rel + 20) / 40: drop three bits, then multiply by the reciprocal of 5
   assign rel_sum  = {1'b0, item_rel} + {1'b0, NOISE_RND};
   assign rel_prod = 64'(rel_sum[32:3]) * 64'(NOISE_RCP);

   always_comb begin
      priority if (item_rel < REL_A) begin
         noise = NOISE_A;
      end else if (item_rel < REL_B) begin
         noise = NOISE_B;
      end else if (item_rel < REL_C) begin
         noise = NOISE_C;
      end else begin
         noise = {2'b00, rel_prod[63:34]};
      end
   end

   // shared multiplier operands; the product is registered every cycle
   always_comb begin
      ma   = '0;
      mb   = '0;
      mneg = 1'b0;
      unique case (state_ff)
         S_QTT: begin
            ma = t_eff;
            mb = t_eff;
         end
         S_P1: begin
            ma   = t_eff;
            mb   = mag32(ext_s(vcross_ff));
            mneg = vcross_ff[31];
         end
         S_P2: begin
            ma = tt_ff;
            mb = vvel_ff;
         end
         S_P3: begin
            ma = t_eff;
            mb = vvel_ff;
         end
         S_KVW: begin
            ma = {15'd0, one_m_kx};
            mb = ppxx_ff;
         end
         S_U1: begin
            ma   = {15'd0, one_m_kx};
            mb   = ppxv_mag;
            mneg = ppxv_ff[31];
         end
         S_U2: begin
            ma   = mag32(ext_s(kv_ff));
            mb   = ppxv_mag;
            mneg = kv_ff[31] ^ ppxv_ff[31];
         end
         default: ;
      endcase
   end

   always_comb begin
      div_start = 1'b0;
      div_num   = '0;
      div_den   = '0;
      state_in  = state_ff;
      unique case (state_ff)
         S_IDLE: if (item_go) begin
            state_in = S_RDIV;
         end
         S_RDIV: begin
            if (item_first) begin
               state_in = S_WAIT;
            end else begin
               div_start = 1'b1;
               div_num   = DIV_NW'({cfg_q, {FRAC{1'b0}}});
               div_den   = DIV_DW'(t_eff);
               state_in  = S_QT;
            end
         end
         S_QT: if (div_done) begin
            div_start = 1'b1;
            div_num   = DIV_NW'({qt_sat, {FRAC{1'b0}}});
            div_den   = DIV_DW'(t_eff);
            state_in  = S_QTT;
         end
         S_QTT: if (div_done) begin
            state_in = S_P1;
         end
         S_P1: state_in = S_P2;
         S_P2: state_in = S_P3;
         S_P3: state_in = S_P4;
         S_P4: state_in = S_KX;
         S_KX: begin
            div_start = 1'b1;
            div_num   = DIV_NW'({ppxx_ff, {FRAC{1'b0}}}) + DIV_NW'(s_sum >> 1);
            div_den   = s_sum;
            state_in  = S_KXW;
         end
         S_KXW: if (div_done) begin
            div_start = 1'b1;
            div_num   = DIV_NW'({ppxv_mag, {FRAC{1'b0}}}) + DIV_NW'(s_sum >> 1);
            div_den   = s_sum;
            state_in  = S_KVW;
         end
         S_KVW: if (div_done) begin
            state_in = S_U1;
         end
         S_U1: state_in = S_U2;
         S_U2: state_in = S_U3;
         S_U3: state_in = S_WAIT;
         S_WAIT: if (!lanes_busy) begin
            state_in = S_DONE;
         end
         S_DONE: if (out_free) begin
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   kcv_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_quot)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         vpos_ff   <= RST_POS;
         vcross_ff <= RST_CROSS;
         vvel_ff   <= RST_VEL;
      end else begin
         state_ff <= state_in;
         unique case (state_ff)
            S_RDIV: if (item_first) begin
               vpos_ff   <= cfg_pos;
               vcross_ff <= cfg_cross;
               vvel_ff   <= cfg_vel;
            end
            S_U1: vpos_ff   <= sat_u(qres);
            S_U2: vcross_ff <= sat_s(qres);
            S_U3: vvel_ff   <= sat_u(ext_u(ppvv_ff) - qres);
            default: ;
         endcase
      end
      prod_ff <= 64'(ma) * 64'(mb);
      neg_ff  <= mneg;
      unique case (state_ff)
         S_RDIV: begin
            r_ff  <= noise;
            kx_ff <= ONE17;
         end
         S_QT:  if (div_done) begin
            qt_ff <= qt_sat;
         end
         S_QTT: if (div_done) begin
            qtt_ff <= div_quot;
         end
         S_P1: tt_ff <= sat_u(qres);
         S_P2: m1_ff <= qres;
         S_P3: m2_ff <= qres;
         S_P4: begin
            ppxx_ff <= sat_u(ext_u(vpos_ff) + (m1_ff <<< 1) + m2_ff + ext_u(cfg_q));
            ppxv_ff <= sat_s(ext_s(vcross_ff) + qres + (ext_u(qt_ff) <<< 1));
            ppvv_ff <= sat_u(ext_u(vvel_ff) + $signed(WW'(qtt_ff) << 2));
         end
         S_KXW: if (div_done) begin
            kx_ff <= div_quot[16:0];
         end
         S_KVW: if (div_done) begin
            kv_ff <= sat_s(kv_wide);
         end
         default: ;
      endcase
   end

   always_comb begin
      lane_ctrl.go    = ((state_ff == S_RDIV) && item_first) ||
                        ((state_ff == S_KVW) && div_done);
      lane_ctrl.first = item_first;
      lane_ctrl.kx    = kx_ff;
      lane_ctrl.kv    = kv_ff;
      lane_ctrl.t     = t_eff;
   end

   assign idle      = state_ff == S_IDLE;
   assign res_valid = state_ff == S_DONE;
   assign res_kx    = kx_ff;
   assign res_noise = r_ff;
   assign res_var   = vpos_ff;

endmodule

[tb/kcv_tb_pkg.sv]
package kcv_tb_pkg;

   typedef enum logic [2:0] {
      REG_INTERVAL = 3'd0,
      REG_NOISE    = 3'd1,
      REG_POS_VAR  = 3'd2,
      REG_CROSS    = 3'd3,
      REG_VEL_VAR  = 3'd4
   } csr_index_type;

endpackage

[tb/kcv_tracker_checker.sv]
module kcv_tracker_checker import kcv_pkg::*; import kcv_tb_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [127:0] req_tdata,   // meas_x, meas_y, meas_z, reliability
   input  logic [0:0]   req_tuser,   // start_track
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [183:0] rsp_tdata,   // est_x, est_y, est_z, pos_gain(17), meas_noise,
                                     // pos_variance, zero pad
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [4:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   input  logic         csr_pready,
   output int           fail_count,
   output int           pending
);

   localparam longint M32 = 64'hFFFF_FFFF;
   localparam longint S_MAX = 64'sd2147483647;
   localparam longint S_MIN = -64'sd2147483648;
   localparam longint UNIT = 64'sd65536;

   typedef struct {
      logic [31:0] est_x;
      logic [31:0] est_y;
      logic [31:0] est_z;
      logic [16:0] gain;
      logic [31:0] noise;
      logic [31:0] pvar;
   } estimate_type;

   estimate_type estimate_q[$];

   logic [31:0] interval_reg, noise_reg, pos_var_reg, cross_reg, vel_var_reg;
   longint trk_pos[3], trk_vel[3];
   longint cov_pp, cov_pv, cov_vv;

   function automatic longint sx(input logic [31:0] v);
      return longint'($signed(v));
   endfunction

   function automatic longint clip_s(input longint v);
      return v > S_MAX ? S_MAX : (v < S_MIN ? S_MIN : v);
   endfunction

   function automatic longint clip_u(input longint v);
      return v < 0 ? 0 : (v > M32 ? M32 : v);
   endfunction

   function automatic longint unsigned magnitude(input longint v);
      longint unsigned m;
      m = v < 0 ? longint'(-v) : v;
      return m > M32 ? M32 : m;
   endfunction

   // round half away from zero on magnitudes
   function automatic longint fx_mul(input longint a, input longint b);
      longint unsigned p;
      longint r;
      p = magnitude(a) * magnitude(b);
      r = longint'((p + 64'd32768) >> 16);
      return ((a < 0) != (b < 0)) ? -r : r;
   endfunction

   function automatic longint unsigned fx_div_rnd(input longint unsigned num,
                                                  input longint unsigned den);
      if (den == 0) begin
         return M32;
      end
      return (((num & M32) << 16) + den / 2) / den;
   endfunction

   function automatic longint noise_for(input logic [31:0] rel);
      longint unsigned r;
      r = rel;
      if (r < (64'd5 << 15)) begin
         return (UNIT + 10) / 20;
      end else if (r < (64'd8 << 16)) begin
         return (UNIT + 2) / 5;
      end else if (r < (64'd20 << 16)) begin
         return UNIT / 2;
      end
      return longint'((r + 20) / 40);
   endfunction

   task automatic restore_state();
      for (int a = 0; a < 3; a++) begin
         trk_pos[a] = 0;
         trk_vel[a] = 0;
      end
      cov_pp = pos_var_reg;
      cov_pv = sx(cross_reg);
      cov_vv = vel_var_reg;
   endtask

   task automatic restore_state_covariance();
      cov_pp = pos_var_reg;
      cov_pv = sx(cross_reg);
      cov_vv = vel_var_reg;
   endtask

   task automatic track_fix(input logic start, input logic [127:0] d, output estimate_type e);
      longint est[3];
      longint r, kx, kv, t, q, tt, qt, qtt, ppxx, ppxv, ppvv, xhat, y;
      longint unsigned s, kvm;
      r = noise_for(d[127:96]);
      if (start) begin
         for (int a = 0; a < 3; a++) begin
            trk_pos[a] = sx(d[32*a +: 32]);
            trk_vel[a] = 0;
            est[a] = trk_pos[a];
         end
         restore_state_covariance();
         kx = UNIT;
      end else begin
         t = interval_reg != 0 ? longint'(interval_reg) : 1;
         q = noise_reg;
         tt = clip_u(fx_mul(t, t));
         qt = clip_u(longint'((longint'(q) << 16) / t));
         qtt = (qt << 16) / t;
         ppxx = clip_u(cov_pp + 2 * fx_mul(t, cov_pv) + fx_mul(tt, cov_vv) + q);
         ppxv = clip_s(cov_pv + fx_mul(t, cov_vv) + 2 * qt);
         ppvv = clip_u(cov_vv + 4 * qtt);
         s = ppxx + r;
         kx = fx_div_rnd(ppxx, s);
         kvm = fx_div_rnd(magnitude(ppxv), s);
         kv = ppxv < 0 ? clip_s(-longint'(kvm)) : clip_s(longint'(kvm));
         for (int a = 0; a < 3; a++) begin
            xhat = clip_s(trk_pos[a] + fx_mul(trk_vel[a], t));
            y = sx(d[32*a +: 32]) - xhat;
            trk_pos[a] = clip_s(xhat + fx_mul(y, kx));
            trk_vel[a] = clip_s(trk_vel[a] + fx_mul(y, kv));
            est[a] = trk_pos[a];
         end
         cov_pp = clip_u(fx_mul(UNIT - kx, ppxx));
         cov_pv = clip_s(fx_mul(UNIT - kx, ppxv));
         cov_vv = clip_u(ppvv - fx_mul(kv, ppxv));
      end
      e.est_x = est[0][31:0];
      e.est_y = est[1][31:0];
      e.est_z = est[2][31:0];
      e.gain = kx[16:0];
      e.noise = r[31:0];
      e.pvar = cov_pp[31:0];
   endtask

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         fail_count++;
      end
   endtask

   initial begin
      fail_count = 0;
      pending = 0;
   end

   always @(posedge clock) begin
      estimate_type e;
      if (reset) begin
         interval_reg = RST_T;
         noise_reg = RST_Q;
         pos_var_reg = RST_POS;
         cross_reg = RST_CROSS;
         vel_var_reg = RST_VEL;
         restore_state();
         estimate_q.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (estimate_q.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual %h", $time, rsp_tdata);
               fail_count++;
            end else begin
               e = estimate_q.pop_front();
               compare_field("est_x", e.est_x, rsp_tdata[31:0]);
               compare_field("est_y", e.est_y, rsp_tdata[63:32]);
               compare_field("est_z", e.est_z, rsp_tdata[95:64]);
               compare_field("pos_gain", 32'(e.gain), 32'(rsp_tdata[112:96]));
               compare_field("meas_noise", e.noise, rsp_tdata[144:113]);
               compare_field("pos_variance", e.pvar, rsp_tdata[176:145]);
            end
         end
         if (req_tvalid && req_tready) begin
            track_fix(req_tuser[0], req_tdata, e);
            estimate_q.push_back(e);
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[4:2])
               REG_INTERVAL: interval_reg = csr_pwdata;
               REG_NOISE:    noise_reg = csr_pwdata;
               REG_POS_VAR:  pos_var_reg = csr_pwdata;
               REG_CROSS:    cross_reg = csr_pwdata;
               REG_VEL_VAR:  vel_var_reg = csr_pwdata;
               default: ;
            endcase
         end
      end
      pending = estimate_q.size();
   end

endmodule

[tb/tb_kalman_cv_position_tracker.sv]
module tb_kalman_cv_position_tracker import kcv_pkg::*; import kcv_tb_pkg::*;;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [127:0] req_tdata;   // meas_x, meas_y, meas_z, reliability
   logic [0:0]   req_tuser;   // start_track
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [183:0] rsp_tdata;   // est_x, est_y, est_z, pos_gain(17), meas_noise,
                              // pos_variance, zero pad
   logic         csr_psel;
   logic         csr_penable;
   logic         csr_pwrite;
   logic [4:0]   csr_paddr;
   logic [31:0]  csr_pwdata;
   logic [31:0]  csr_prdata;
   logic         csr_pready;
   int           fail_count;
   int           pending;

   bit send_idle_off;
   bit recv_idle_off;
   int results_seen;

   kalman_cv_position_tracker dut (.*);

   kcv_tracker_checker checker_i (.*);

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   task automatic csr_write(input csr_index_type idx, input logic [31:0] value);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= 5'(idx) << 2;
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   // called at a falling edge, returns at a falling edge after the transfer
   task automatic send_fix(input logic start, input logic [31:0] x, input logic [31:0] y,
                           input logic [31:0] z, input logic [31:0] rel);
      int gap;
      gap = send_idle_off ? 0 : $urandom_range(3);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= start;
      req_tdata <= {rel, z, y, x};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (300) @(negedge clock);
   endtask

   task automatic load_config(input logic [31:0] t, input logic [31:0] q,
                              input logic [31:0] pv, input logic [31:0] cv,
                              input logic [31:0] vv);
      csr_write(REG_INTERVAL, t);
      csr_write(REG_NOISE, q);
      csr_write(REG_POS_VAR, pv);
      csr_write(REG_CROSS, cv);
      csr_write(REG_VEL_VAR, vv);
   endtask

   function automatic logic [31:0] pick_rel();
      case ($urandom_range(5))
         0: return $urandom_range(32'h27FFF);
         1: return $urandom_range(32'h7FFFF, 32'h28000);
         2: return $urandom_range(32'h13FFFF, 32'h80000);
         3: return $urandom_range(32'hFFFFFF, 32'h140000);
         default: return $urandom();
      endcase
   endfunction

   task automatic random_tracks(input int count);
      logic [31:0] base[3];
      logic [31:0] step[3];
      logic [31:0] m[3];
      for (int n = 0; n < count; n++) begin
         if (n % 100 == 0) begin
            send_idle_off = ($urandom_range(3) == 0);
         end
         if (n == 0 || $urandom_range(15) == 0) begin
            for (int a = 0; a < 3; a++) begin
               base[a] = $urandom_range(8) == 0 ? $urandom() : $urandom_range(32'h00FF_FFFF);
               step[a] = $urandom_range(32'h3FFFF) - 32'h1FFFF;
            end
            send_fix(1'b1, base[0], base[1], base[2], pick_rel());
         end else begin
            for (int a = 0; a < 3; a++) begin
               base[a] = base[a] + step[a];
               m[a] = $urandom_range(10) == 0 ? $urandom()
                                              : base[a] + $urandom_range(32'hFFFF) - 32'h7FFF;
            end
            send_fix($urandom_range(40) == 0, m[0], m[1], m[2], pick_rel());
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      send_idle_off = 1'b0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // filter against the reset state before any track is started
      send_fix(1'b0, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000, 32'h0000_0000);
      send_fix(1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'h0002_7FFF);
      send_fix(1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0002_8000);
      send_fix(1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 32'h0007_FFFF);
      send_fix(1'b0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0008_0000);
      send_fix(1'b0, 32'h0000_1000, 32'h0000_2000, 32'h0000_3000, 32'h0013_FFFF);
      send_fix(1'b0, 32'h0000_1100, 32'h0000_2100, 32'h0000_3100, 32'h0014_0000);
      send_fix(1'b0, 32'h0000_1200, 32'h0000_2200, 32'h0000_3200, 32'hFFFF_FFFF);
      send_fix(1'b1, 32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, 32'hFFFF_FFFF);
      send_fix(1'b0, 32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFF, 32'h0000_0001);
      drain();

      // zero interval counts as one LSB
      load_config(32'h0, 32'h0000_FFFF, 32'h0, 32'h8000_0000, 32'h0);
      send_fix(1'b0, 32'h0000_4000, 32'h0000_4000, 32'h0000_4000, 32'h0001_0000);
      send_fix(1'b1, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0001_0000);
      send_fix(1'b0, 32'h0001_1000, 32'h0002_1000, 32'h0003_1000, 32'h0010_0000);
      send_fix(1'b0, 32'h0001_2000, 32'h0002_2000, 32'h0003_2000, 32'h0030_0000);
      drain();
      load_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      send_fix(1'b1, 32'h0, 32'h0, 32'h0, 32'h0);
      send_fix(1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 32'h0);
      send_fix(1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h1, 32'hFFFF_FFFF);
      drain();

      load_config(RST_T, RST_Q, RST_POS, RST_CROSS, RST_VEL);
      random_tracks(400);
      drain();
      load_config(32'h0000_4000, 32'h0000_0001, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_0100);
      random_tracks(250);
      drain();
      load_config(32'h0002_0000, 32'h0000_1000, 32'h0, 32'h0000_0000, 32'h0010_0000);
      random_tracks(250);
      drain();
      load_config($urandom(), $urandom(), $urandom(), $urandom(), $urandom());
      random_tracks(150);
      drain();
      load_config($urandom_range(32'h0004_0000, 1), $urandom_range(32'hFFFF),
                  $urandom_range(32'h000F_FFFF), $urandom_range(32'h000F_FFFF) - 32'h0007_FFFF,
                  $urandom_range(32'h000F_FFFF));
      random_tracks(200);
      drain();

      if (fail_count == 0) begin
         $display("tb_kalman_cv_position_tracker: clean");
      end else begin
         $display("tb_kalman_cv_position_tracker: errors");
      end
      $finish;
   end

   initial begin
      int gap;
      rsp_tready = 1'b0;
      recv_idle_off = 1'b0;
      results_seen = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (results_seen % 80 == 0) begin
            recv_idle_off = ($urandom_range(3) == 0);
         end
         // hold off long enough that the block stalls its input
         if (results_seen == 40 || results_seen == 700) begin
            rsp_tready <= 1'b0;
            repeat (2000) @(negedge clock);
         end
         gap = recv_idle_off ? 0 : $urandom_range(3);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         results_seen++;
         @(negedge clock);
      end
   end

   initial begin
      #20_000_000;
      $display("tb_kalman_cv_position_tracker: errors");
      $finish;
   end

endmodule
